>>> rtl/core/qalu_pkg.sv
// quaternion alu package: default widths and operation codes
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps

package qalu_pkg;

   localparam int COMP_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 12;
   localparam int OP_WIDTH       = 3;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD   = 3'd0,
      OP_SUB   = 3'd1,
      OP_PROD  = 3'd2,
      OP_SCALE = 3'd3,
      OP_CONJ  = 3'd4,
      OP_MAG   = 3'd5,
      OP_NORM  = 3'd6
   } op_type;

endpackage

>>> rtl/core/qalu_if.sv
// request and response channel interfaces of the quaternion alu
// depends on qalu_pkg
`timescale 1ns / 1ps

interface qalu_req_if import qalu_pkg::*; #(parameter int W = COMP_WIDTH_DEF) ();
   logic                valid;
   logic                ready;
   logic [OP_WIDTH-1:0] req_type;
   logic signed [W-1:0] a_r;
   logic signed [W-1:0] a_x;
   logic signed [W-1:0] a_y;
   logic signed [W-1:0] a_z;
   logic signed [W-1:0] b_r;
   logic signed [W-1:0] b_x;
   logic signed [W-1:0] b_y;
   logic signed [W-1:0] b_z;
   logic signed [W-1:0] scale_factor;

   modport source (output valid, req_type, a_r, a_x, a_y, a_z, b_r, b_x, b_y, b_z,
                   scale_factor, input ready);
   modport sink (input valid, req_type, a_r, a_x, a_y, a_z, b_r, b_x, b_y, b_z,
                 scale_factor, output ready);
endinterface

interface qalu_rsp_if import qalu_pkg::*; #(parameter int W = COMP_WIDTH_DEF) ();
   logic                valid;
   logic                ready;
   logic signed [W-1:0] res_r;
   logic signed [W-1:0] res_x;
   logic signed [W-1:0] res_y;
   logic signed [W-1:0] res_z;
   logic                overflow;

   modport source (output valid, res_r, res_x, res_y, res_z, overflow, input ready);
   modport sink (input valid, res_r, res_x, res_y, res_z, overflow, output ready);
endinterface

>>> rtl/core/qalu_front.sv
// front end: products, sums, rounding and the simple operations (three stages)
// depends on qalu_pkg and qalu_if
`timescale 1ns / 1ps

module qalu_front import qalu_pkg::*; #(
   parameter int COMP_WIDTH = COMP_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   localparam int W      = COMP_WIDTH,
   localparam int SW     = 2 * COMP_WIDTH + 2,
   localparam int RW     = 2 * COMP_WIDTH + 1,
   localparam int SIDE_W = 8 * COMP_WIDTH + 8
) (
   input  logic              clock,
   input  logic              reset,
   qalu_req_if.sink          req,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [SIDE_W-1:0] out_side,
   output logic [RW-1:0]     out_sq
);

   localparam logic signed [W-1:0]  MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0]  MINV = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);

   function automatic logic [W:0] sat1(input logic signed [W:0] v);
      logic [W:0] r;
      if (v > $signed({1'b0, MAXV})) r = {1'b1, MAXV};
      else if (v < $signed({1'b1, MINV})) r = {1'b1, MINV};
      else r = {1'b0, v[W-1:0]};
      return r;
   endfunction

   function automatic logic [W:0] satr(input logic signed [SW-1:0] v);
      logic [W:0] r;
      if (v > SW'(MAXV)) r = {1'b1, MAXV};
      else if (v < SW'(MINV)) r = {1'b1, MINV};
      else r = {1'b0, v[W-1:0]};
      return r;
   endfunction

   // stage 1: multipliers
   logic                  v1_ff;
   logic                  rdy1;
   logic [OP_WIDTH-1:0]   op1_ff;
   logic signed [W-1:0]   a1_ff [4];
   logic signed [W-1:0]   b1_ff [4];
   logic signed [2*W-1:0] p1_ff [4][4];
   logic signed [W-1:0]   a_c [4];
   logic signed [W-1:0]   b_c [4];
   logic signed [W-1:0]   bm_c [4];

   // stage 2: sums
   logic                  v2_ff;
   logic                  rdy2;
   logic [OP_WIDTH-1:0]   op2_ff;
   logic signed [SW-1:0]  sum2_ff [4];
   logic [RW-1:0]         sq2_ff;
   logic [W-1:0]          dres2_ff [4];
   logic                  dov2_ff;
   logic [3:0]            neg2_ff;
   logic [W-1:0]          mag2_ff [4];
   logic signed [SW-1:0]  xd [4];
   logic signed [SW-1:0]  ps [4];
   logic signed [SW-1:0]  sum_c [4];
   logic signed [SW-1:0]  sq_c;
   logic [W-1:0]          dres_c [4];
   logic                  dov_c;
   logic [3:0]            neg_c;
   logic [W-1:0]          mag_c [4];
   logic [W:0]            t2;

   // stage 3: rounding
   logic                  v3_ff;
   logic                  rdy3;
   logic [SIDE_W-1:0]     side3_ff;
   logic [RW-1:0]         sq3_ff;
   logic [W-1:0]          res_c [4];
   logic                  ov_c;
   logic signed [SW-1:0]  rr;
   logic [W:0]            t3;

   assign a_c = '{req.a_r, req.a_x, req.a_y, req.a_z};
   assign b_c = '{req.b_r, req.b_x, req.b_y, req.b_z};

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (req.req_type == OP_SCALE) bm_c[i] = req.scale_factor;
         else if (req.req_type == OP_MAG || req.req_type == OP_NORM) bm_c[i] = a_c[i];
         else bm_c[i] = b_c[i];
      end
   end

   assign rdy1      = !v1_ff || rdy2;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy3      = !v3_ff || out_ready;
   assign req.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && rdy1) begin
         op1_ff <= req.req_type;
         for (int i = 0; i < 4; i++) begin
            a1_ff[i] <= a_c[i];
            b1_ff[i] <= b_c[i];
            for (int j = 0; j < 4; j++) p1_ff[i][j] <= a_c[i] * bm_c[j];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) xd[i] = SW'(p1_ff[i][i]);
      ps[0] = SW'(p1_ff[0][0]) - SW'(p1_ff[1][1]) - SW'(p1_ff[2][2]) - SW'(p1_ff[3][3]);
      ps[1] = SW'(p1_ff[0][1]) + SW'(p1_ff[1][0]) + SW'(p1_ff[2][3]) - SW'(p1_ff[3][2]);
      ps[2] = SW'(p1_ff[0][2]) - SW'(p1_ff[1][3]) + SW'(p1_ff[2][0]) + SW'(p1_ff[3][1]);
      ps[3] = SW'(p1_ff[0][3]) + SW'(p1_ff[1][2]) - SW'(p1_ff[2][1]) + SW'(p1_ff[3][0]);
      sq_c  = xd[0] + xd[1] + xd[2] + xd[3];
      for (int i = 0; i < 4; i++) begin
         sum_c[i] = (op1_ff == OP_SCALE) ? xd[i] : ps[i];
         neg_c[i] = a1_ff[i][W-1];
         mag_c[i] = a1_ff[i][W-1] ? W'(-a1_ff[i]) : W'(a1_ff[i]);
         dres_c[i] = '0;
      end
      dov_c = 1'b0;
      t2    = '0;
      unique case (op1_ff)
         OP_ADD: begin
            for (int i = 0; i < 4; i++) begin
               t2 = sat1((W+1)'(a1_ff[i]) + (W+1)'(b1_ff[i]));
               dres_c[i] = t2[W-1:0];
               dov_c = dov_c | t2[W];
            end
         end
         OP_SUB: begin
            for (int i = 0; i < 4; i++) begin
               t2 = sat1((W+1)'(a1_ff[i]) - (W+1)'(b1_ff[i]));
               dres_c[i] = t2[W-1:0];
               dov_c = dov_c | t2[W];
            end
         end
         OP_CONJ: begin
            dres_c[0] = a1_ff[0];
            for (int i = 1; i < 4; i++) begin
               t2 = sat1(-(W+1)'(a1_ff[i]));
               dres_c[i] = t2[W-1:0];
               dov_c = dov_c | t2[W];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (v1_ff && rdy2) begin
         op2_ff  <= op1_ff;
         sq2_ff  <= sq_c[RW-1:0];
         dov2_ff <= dov_c;
         neg2_ff <= neg_c;
         for (int i = 0; i < 4; i++) begin
            sum2_ff[i]  <= sum_c[i];
            dres2_ff[i] <= dres_c[i];
            mag2_ff[i]  <= mag_c[i];
         end
      end
   end

   always_comb begin
      ov_c = 1'b0;
      rr   = '0;
      t3   = '0;
      for (int i = 0; i < 4; i++) res_c[i] = dres2_ff[i];
      if (op2_ff == OP_PROD || op2_ff == OP_SCALE) begin
         for (int i = 0; i < 4; i++) begin
            rr = (sum2_ff[i] + HALF) >>> FRAC_BITS;
            t3 = satr(rr);
            res_c[i] = t3[W-1:0];
            ov_c = ov_c | t3[W];
         end
      end else begin
         ov_c = dov2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (v2_ff && rdy3) begin
         sq3_ff   <= sq2_ff;
         side3_ff <= {op2_ff, neg2_ff,
                      mag2_ff[3], mag2_ff[2], mag2_ff[1], mag2_ff[0],
                      res_c[3], res_c[2], res_c[1], res_c[0], ov_c};
      end
   end

   assign out_valid = v3_ff;
   assign out_side  = side3_ff;
   assign out_sq    = sq3_ff;

endmodule

>>> rtl/core/qalu_sqrt_cell.sv
// square root cell: decides one root bit from the running remainder
// depends on qalu_pkg
`timescale 1ns / 1ps

module qalu_sqrt_cell import qalu_pkg::*; #(
   parameter int W      = COMP_WIDTH_DEF,
   parameter int BIT    = 0,
   parameter int SIDE_W = 8 * COMP_WIDTH_DEF + 8,
   localparam int RW    = 2 * W + 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [SIDE_W-1:0] in_side,
   input  logic [RW-1:0]     in_rem,
   input  logic [W:0]        in_root,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [SIDE_W-1:0] out_side,
   output logic [RW-1:0]     out_rem,
   output logic [W:0]        out_root
);

   logic              v_ff;
   logic [SIDE_W-1:0] side_ff;
   logic [RW-1:0]     rem_ff;
   logic [RW-1:0]     rem_in;
   logic [W:0]        root_ff;
   logic [W:0]        root_in;
   logic [RW-1:0]     trial;
   logic              ge;

   // only root bits above this one can be set, so the trial term never overlaps them
   assign trial   = (RW'(in_root) << (BIT + 1)) | (RW'(1) << (2 * BIT));
   assign ge      = in_rem >= trial;
   assign rem_in  = ge ? in_rem - trial : in_rem;
   assign root_in = ge ? in_root | ((W+1)'(1) << BIT) : in_root;

   assign in_ready = !v_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         side_ff <= in_side;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign out_valid = v_ff;
   assign out_side  = side_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;

endmodule

>>> rtl/core/qalu_div_cell.sv
// divider cell: one quotient bit for each of the four lanes
// depends on qalu_pkg
`timescale 1ns / 1ps

module qalu_div_cell import qalu_pkg::*; #(
   parameter int W      = COMP_WIDTH_DEF,
   parameter int F      = FRAC_BITS_DEF,
   parameter int BIT    = 0,
   parameter int SIDE_W = 8 * COMP_WIDTH_DEF + 8,
   localparam int NW    = W + F + 1,
   localparam int QW    = F + 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [SIDE_W-1:0] in_side,
   input  logic [W:0]        in_m,
   input  logic [4*NW-1:0]   in_rem,
   input  logic [4*QW-1:0]   in_q,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [SIDE_W-1:0] out_side,
   output logic [W:0]        out_m,
   output logic [4*NW-1:0]   out_rem,
   output logic [4*QW-1:0]   out_q
);

   logic              v_ff;
   logic [SIDE_W-1:0] side_ff;
   logic [W:0]        m_ff;
   logic [4*NW-1:0]   rem_ff;
   logic [4*NW-1:0]   rem_in;
   logic [4*QW-1:0]   q_ff;
   logic [4*QW-1:0]   q_in;
   logic [NW-1:0]     trial;

   assign trial = NW'(in_m) << BIT;

   always_comb begin
      rem_in = in_rem;
      q_in   = in_q;
      for (int i = 0; i < 4; i++) begin
         if (in_rem[i*NW +: NW] >= trial) begin
            rem_in[i*NW +: NW] = in_rem[i*NW +: NW] - trial;
            q_in[i*QW + BIT]   = 1'b1;
         end
      end
   end

   assign in_ready = !v_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         side_ff <= in_side;
         m_ff    <= in_m;
         rem_ff  <= rem_in;
         q_ff    <= q_in;
      end
   end

   assign out_valid = v_ff;
   assign out_side  = side_ff;
   assign out_m     = m_ff;
   assign out_rem   = rem_ff;
   assign out_q     = q_ff;

endmodule

>>> rtl/core/quaternion_alu.sv
// quaternion alu top level: front end, square root chain, divider chain, result register
// depends on qalu_pkg, qalu_if, qalu_front, qalu_sqrt_cell and qalu_div_cell
`timescale 1ns / 1ps
//
//   channel   direction   handshake     payload
//   req       in          valid/ready   req_type, a_r..a_z, b_r..b_z, scale_factor
//   rsp       out         valid/ready   res_r..res_z, overflow
//
// one transfer in per cycle while the rsp side keeps taking results; each item passes
// through three front stages, one cell per root bit, one setup stage, one cell per
// quotient bit and the result register
// synchronous reset clears the valid bits only
// each stage holds while its successor cannot take, so bubbles close up under a stall

module quaternion_alu import qalu_pkg::*; #(
   parameter int COMP_WIDTH = COMP_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   qalu_req_if.sink   req,
   qalu_rsp_if.source rsp
);

   localparam int W      = COMP_WIDTH;
   localparam int F      = FRAC_BITS;
   localparam int RW     = 2 * W + 1;
   localparam int NW     = W + F + 1;
   localparam int QW     = F + 1;
   localparam int EW     = W + F + 2;
   localparam int SIDE_W = 8 * W + 8;
   localparam int NS     = W + 1;
   localparam int ND     = F + 1;
   localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
   localparam logic [EW-1:0] MAXE = (EW'(1) << (W - 1)) - EW'(1);
   localparam logic [EW-1:0] LIME = EW'(1) << (W - 1);
   localparam logic [EW-1:0] ONEE = EW'(1) << F;

   // square root chain
   logic              s_valid [0:NS];
   logic              s_ready [0:NS];
   logic [SIDE_W-1:0] s_side  [0:NS];
   logic [RW-1:0]     s_rem   [0:NS];
   logic [W:0]        s_root  [0:NS];

   // divider chain
   logic              d_valid [0:ND];
   logic              d_ready [0:ND];
   logic [SIDE_W-1:0] d_side  [0:ND];
   logic [W:0]        d_m     [0:ND];
   logic [4*NW-1:0]   d_rem   [0:ND];
   logic [4*QW-1:0]   d_q     [0:ND];

   qalu_front #(.COMP_WIDTH(W), .FRAC_BITS(F)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .out_valid (s_valid[0]),
      .out_ready (s_ready[0]),
      .out_side  (s_side[0]),
      .out_sq    (s_rem[0])
   );
   assign s_root[0] = '0;

   for (genvar g = 0; g < NS; g++) begin : g_sqrt
      qalu_sqrt_cell #(.W(W), .BIT(W - g), .SIDE_W(SIDE_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (s_valid[g]),
         .in_ready  (s_ready[g]),
         .in_side   (s_side[g]),
         .in_rem    (s_rem[g]),
         .in_root   (s_root[g]),
         .out_valid (s_valid[g+1]),
         .out_ready (s_ready[g+1]),
         .out_side  (s_side[g+1]),
         .out_rem   (s_rem[g+1]),
         .out_root  (s_root[g+1])
      );
   end

   // divider setup: dividend is |c| * 2^F + m/2 for round half away from zero
   logic              p_v_ff;
   logic [SIDE_W-1:0] p_side_ff;
   logic [W:0]        p_m_ff;
   logic [4*NW-1:0]   p_rem_ff;
   logic [4*NW-1:0]   p_rem_in;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         p_rem_in[i*NW +: NW] = (NW'(s_side[NS][1 + 4*W + i*W +: W]) << F)
                              + NW'(s_root[NS] >> 1);
      end
   end

   assign s_ready[NS] = !p_v_ff || d_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
      end else if (s_ready[NS]) begin
         p_v_ff <= s_valid[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (s_valid[NS] && s_ready[NS]) begin
         p_side_ff <= s_side[NS];
         p_m_ff    <= s_root[NS];
         p_rem_ff  <= p_rem_in;
      end
   end

   assign d_valid[0] = p_v_ff;
   assign d_side[0]  = p_side_ff;
   assign d_m[0]     = p_m_ff;
   assign d_rem[0]   = p_rem_ff;
   assign d_q[0]     = '0;

   for (genvar g = 0; g < ND; g++) begin : g_div
      qalu_div_cell #(.W(W), .F(F), .BIT(F - g), .SIDE_W(SIDE_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (d_valid[g]),
         .in_ready  (d_ready[g]),
         .in_side   (d_side[g]),
         .in_m      (d_m[g]),
         .in_rem    (d_rem[g]),
         .in_q      (d_q[g]),
         .out_valid (d_valid[g+1]),
         .out_ready (d_ready[g+1]),
         .out_side  (d_side[g+1]),
         .out_m     (d_m[g+1]),
         .out_rem   (d_rem[g+1]),
         .out_q     (d_q[g+1])
      );
   end

   // result selection and output register
   logic                o_v_ff;
   logic [W-1:0]        o_res_ff [4];
   logic                o_ov_ff;
   logic [W-1:0]        res_c [4];
   logic                ov_c;
   logic [OP_WIDTH-1:0] f_op;
   logic [3:0]          f_neg;
   logic [EW-1:0]       qe;
   logic [EW-1:0]       me;

   assign f_op  = d_side[ND][5 + 8*W +: OP_WIDTH];
   assign f_neg = d_side[ND][1 + 8*W +: 4];
   assign me    = EW'(d_m[ND]);

   always_comb begin
      qe   = '0;
      ov_c = 1'b0;
      for (int i = 0; i < 4; i++) res_c[i] = '0;
      if (f_op == OP_MAG) begin
         if (me > MAXE) begin
            res_c[0] = MAXV;
            ov_c = 1'b1;
         end else begin
            res_c[0] = me[W-1:0];
         end
      end else if (f_op == OP_NORM) begin
         if (d_m[ND] == '0) begin
            // all components zero: identity
            if (ONEE > MAXE) begin
               res_c[0] = MAXV;
               ov_c = 1'b1;
            end else begin
               res_c[0] = ONEE[W-1:0];
            end
         end else begin
            for (int i = 0; i < 4; i++) begin
               qe = EW'(d_q[ND][i*QW +: QW]);
               if (f_neg[i]) begin
                  if (qe > LIME) begin
                     res_c[i] = MINV;
                     ov_c = 1'b1;
                  end else begin
                     res_c[i] = -qe[W-1:0];
                  end
               end else begin
                  if (qe > MAXE) begin
                     res_c[i] = MAXV;
                     ov_c = 1'b1;
                  end else begin
                     res_c[i] = qe[W-1:0];
                  end
               end
            end
         end
      end else begin
         for (int i = 0; i < 4; i++) res_c[i] = d_side[ND][1 + i*W +: W];
         ov_c = d_side[ND][0];
      end
   end

   assign d_ready[ND] = !o_v_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (d_ready[ND]) begin
         o_v_ff <= d_valid[ND];
      end
   end

   always_ff @(posedge clock) begin
      if (d_valid[ND] && d_ready[ND]) begin
         o_ov_ff <= ov_c;
         for (int i = 0; i < 4; i++) o_res_ff[i] <= res_c[i];
      end
   end

   assign rsp.valid    = o_v_ff;
   assign rsp.res_r    = o_res_ff[0];
   assign rsp.res_x    = o_res_ff[1];
   assign rsp.res_y    = o_res_ff[2];
   assign rsp.res_z    = o_res_ff[3];
   assign rsp.overflow = o_ov_ff;

endmodule
